/* rtl/pqt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package pqt_pkg;

    // Geometry widths
    localparam int COORD_BITS = 32;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int CROSS_W    = PROD_W + 1;
    localparam int NUM_VERTS  = 4;

    // Tolerance register
    localparam int               TOL_W     = 20;
    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(43);

    // Input word: query point and the four vertices in edge order
    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic signed [COORD_BITS-1:0] v0_x;
        logic signed [COORD_BITS-1:0] v0_y;
        logic signed [COORD_BITS-1:0] v1_x;
        logic signed [COORD_BITS-1:0] v1_y;
        logic signed [COORD_BITS-1:0] v2_x;
        logic signed [COORD_BITS-1:0] v2_y;
        logic signed [COORD_BITS-1:0] v3_x;
        logic signed [COORD_BITS-1:0] v3_y;
    } query_t;

    // Output word
    typedef struct packed {
        logic inside_res;
        logic on_edge;
    } result_t;

    // Per-edge flags that ride along the pipeline
    typedef struct packed {
        logic [NUM_VERTS-1:0] in_box;
        logic [NUM_VERTS-1:0] straddle;
        logic [NUM_VERTS-1:0] rising;
    } edge_flags_t;

    // After the difference stage
    typedef struct packed {
        logic [NUM_VERTS-1:0][DIFF_W-1:0] dx;
        logic [NUM_VERTS-1:0][DIFF_W-1:0] dyp;
        logic [NUM_VERTS-1:0][DIFF_W-1:0] dy;
        logic [NUM_VERTS-1:0][DIFF_W-1:0] dxp;
        edge_flags_t                      flags;
    } prep_t;

    // After the product stage
    typedef struct packed {
        logic [NUM_VERTS-1:0][PROD_W-1:0] pa;
        logic [NUM_VERTS-1:0][PROD_W-1:0] pb;
        edge_flags_t                      flags;
    } prod_t;

    // After the cross product stage
    typedef struct packed {
        logic [NUM_VERTS-1:0][CROSS_W-1:0] xprod;
        edge_flags_t                       flags;
    } cross_t;

endpackage

`default_nettype wire

/* rtl/point_in_quadrilateral_test.sv */
// Channel   Direction  Handshake                    Word
// query     in         query_valid / query_ready    query_t: point and four vertices
// result    out        result_valid / result_ready  result_t: inside_res, on_edge
// config    in         cfg_wr_en, no wait           cfg_wr_data: edge tolerance
//
// Five register stages: differences, products, cross product, edge decisions,
// result. One word enters per cycle while no output stall backs up to the input.
// The 33 x 33 bit products and the 67 bit subtract set the stage split.
// rst_n clears every valid bit and loads the tolerance with its default.
// A stall at the output backs up only the full stages; empty stages still fill.
`timescale 1ns / 1ps
`default_nettype none

module point_in_quadrilateral_test
    import pqt_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             query_valid,
    output logic                  query_ready,
    input  wire query_t           query,
    output logic                  result_valid,
    input  wire logic             result_ready,
    output result_t               result,
    input  wire logic             cfg_wr_en,
    input  wire logic [TOL_W-1:0] cfg_wr_data
);

    logic [TOL_W-1:0] tol_reg;
    prep_t            prep;
    logic             prep_valid;
    logic             prep_ready;
    cross_t           cross_data;
    logic             cross_valid;
    logic             cross_ready;

    // Hold the edge tolerance
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TOL_RESET;
        end
        else if (cfg_wr_en)
        begin
            tol_reg <= cfg_wr_data;
        end
    end

    pqt_prep u_prep (
        .clk         (clk),
        .rst_n       (rst_n),
        .query_valid (query_valid),
        .query_ready (query_ready),
        .query       (query),
        .prep_valid  (prep_valid),
        .prep_ready  (prep_ready),
        .prep        (prep)
    );

    pqt_cross u_cross (
        .clk         (clk),
        .rst_n       (rst_n),
        .prep_valid  (prep_valid),
        .prep_ready  (prep_ready),
        .prep        (prep),
        .cross_valid (cross_valid),
        .cross_ready (cross_ready),
        .cross_data  (cross_data)
    );

    pqt_judge u_judge (
        .clk          (clk),
        .rst_n        (rst_n),
        .tolerance    (tol_reg),
        .cross_valid  (cross_valid),
        .cross_ready  (cross_ready),
        .cross_data   (cross_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

`default_nettype wire

/* rtl/pqt_prep.sv */
`timescale 1ns / 1ps
`default_nettype none

module pqt_prep
    import pqt_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   query_valid,
    output logic        query_ready,
    input  wire query_t query,
    output logic        prep_valid,
    input  wire logic   prep_ready,
    output prep_t       prep
);

    logic signed [COORD_BITS-1:0] vx [NUM_VERTS];
    logic signed [COORD_BITS-1:0] vy [NUM_VERTS];
    logic signed [COORD_BITS-1:0] px;
    logic signed [COORD_BITS-1:0] py;
    prep_t prep_next;
    prep_t prep_reg;
    logic  prep_valid_reg;
    logic  advance;

    // Unpack the vertices
    assign px    = query.point_x;
    assign py    = query.point_y;
    assign vx[0] = query.v0_x;
    assign vy[0] = query.v0_y;
    assign vx[1] = query.v1_x;
    assign vy[1] = query.v1_y;
    assign vx[2] = query.v2_x;
    assign vy[2] = query.v2_y;
    assign vx[3] = query.v3_x;
    assign vy[3] = query.v3_y;

    // Form edge and point differences, bounding box, straddle and rising flags
    always_comb
    begin
        prep_next = '0;
        for (int i = 0; i < NUM_VERTS; i++)
        begin
            prep_next.dx[i]  = {vx[(i+1)%NUM_VERTS][COORD_BITS-1], vx[(i+1)%NUM_VERTS]}
                             - {vx[i][COORD_BITS-1], vx[i]};
            prep_next.dy[i]  = {vy[(i+1)%NUM_VERTS][COORD_BITS-1], vy[(i+1)%NUM_VERTS]}
                             - {vy[i][COORD_BITS-1], vy[i]};
            prep_next.dyp[i] = {py[COORD_BITS-1], py} - {vy[i][COORD_BITS-1], vy[i]};
            prep_next.dxp[i] = {px[COORD_BITS-1], px} - {vx[i][COORD_BITS-1], vx[i]};
            prep_next.flags.in_box[i] =
                ((vx[i] <= px && px <= vx[(i+1)%NUM_VERTS]) ||
                 (vx[(i+1)%NUM_VERTS] <= px && px <= vx[i])) &&
                ((vy[i] <= py && py <= vy[(i+1)%NUM_VERTS]) ||
                 (vy[(i+1)%NUM_VERTS] <= py && py <= vy[i]));
            prep_next.flags.straddle[i] = (vy[i] > py) ^ (vy[(i+1)%NUM_VERTS] > py);
            prep_next.flags.rising[i]   = vy[(i+1)%NUM_VERTS] > py;
        end
    end

    // Advance when the stage is empty or its word moves on
    assign advance     = !prep_valid_reg || prep_ready;
    assign query_ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            prep_valid_reg <= query_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && query_valid)
        begin
            prep_reg <= prep_next;
        end
    end

    assign prep_valid = prep_valid_reg;
    assign prep       = prep_reg;

endmodule

`default_nettype wire

/* rtl/pqt_cross.sv */
`timescale 1ns / 1ps
`default_nettype none

module pqt_cross
    import pqt_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   prep_valid,
    output logic        prep_ready,
    input  wire prep_t  prep,
    output logic        cross_valid,
    input  wire logic   cross_ready,
    output cross_t      cross_data
);

    prod_t  prod_next;
    prod_t  prod_reg;
    logic   prod_valid_reg;
    cross_t cross_next;
    cross_t cross_reg;
    logic   cross_valid_reg;
    logic   advance_prod;
    logic   advance_cross;

    // Multiply: one pair of signed products per edge
    always_comb
    begin
        prod_next       = '0;
        prod_next.flags = prep.flags;
        for (int i = 0; i < NUM_VERTS; i++)
        begin
            prod_next.pa[i] = PROD_W'($signed(prep.dx[i]) * $signed(prep.dyp[i]));
            prod_next.pb[i] = PROD_W'($signed(prep.dy[i]) * $signed(prep.dxp[i]));
        end
    end

    // Subtract the products into the full-width cross product
    always_comb
    begin
        cross_next       = '0;
        cross_next.flags = prod_reg.flags;
        for (int i = 0; i < NUM_VERTS; i++)
        begin
            cross_next.xprod[i] = {prod_reg.pa[i][PROD_W-1], prod_reg.pa[i]}
                                - {prod_reg.pb[i][PROD_W-1], prod_reg.pb[i]};
        end
    end

    // Stage enables, back to front
    assign advance_cross = !cross_valid_reg || cross_ready;
    assign advance_prod  = !prod_valid_reg || advance_cross;
    assign prep_ready    = advance_prod;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg  <= 1'b0;
            cross_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance_prod)
            begin
                prod_valid_reg <= prep_valid;
            end
            if (advance_cross)
            begin
                cross_valid_reg <= prod_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance_prod && prep_valid)
        begin
            prod_reg <= prod_next;
        end
        if (advance_cross && prod_valid_reg)
        begin
            cross_reg <= cross_next;
        end
    end

    assign cross_valid = cross_valid_reg;
    assign cross_data  = cross_reg;

endmodule

`default_nettype wire

/* rtl/pqt_judge.sv */
`timescale 1ns / 1ps
`default_nettype none

module pqt_judge
    import pqt_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [TOL_W-1:0] tolerance,
    input  wire logic             cross_valid,
    output logic                  cross_ready,
    input  wire cross_t           cross_data,
    output logic                  result_valid,
    input  wire logic             result_ready,
    output result_t               result
);

    logic [CROSS_W-1:0]   tol_ext;
    logic [NUM_VERTS-1:0] hit_next;
    logic [NUM_VERTS-1:0] toggle_next;
    logic [NUM_VERTS-1:0] hit_reg;
    logic [NUM_VERTS-1:0] toggle_reg;
    logic                 flag_valid_reg;
    result_t              result_next;
    result_t              result_reg;
    logic                 result_valid_reg;
    logic                 advance_flag;
    logic                 advance_result;

    assign tol_ext = CROSS_W'(tolerance);

    // Decide per edge: near-collinear inside the box, and ray crossing
    always_comb
    begin
        hit_next    = '0;
        toggle_next = '0;
        for (int i = 0; i < NUM_VERTS; i++)
        begin
            hit_next[i] = cross_data.flags.in_box[i] &&
                          ($signed(cross_data.xprod[i]) <= $signed(tol_ext)) &&
                          ($signed(cross_data.xprod[i]) >= -$signed(tol_ext));
            if (cross_data.flags.rising[i])
            begin
                toggle_next[i] = cross_data.flags.straddle[i] &&
                                 !cross_data.xprod[i][CROSS_W-1];
            end
            else
            begin
                toggle_next[i] = cross_data.flags.straddle[i] &&
                                 (cross_data.xprod[i][CROSS_W-1] ||
                                  cross_data.xprod[i] == '0);
            end
        end
    end

    // Fold the edges into parity and the on-edge flag
    always_comb
    begin
        result_next.on_edge    = |hit_reg;
        result_next.inside_res = (|hit_reg) || (^toggle_reg);
    end

    // Stage enables, back to front
    assign advance_result = !result_valid_reg || result_ready;
    assign advance_flag   = !flag_valid_reg || advance_result;
    assign cross_ready    = advance_flag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance_flag)
            begin
                flag_valid_reg <= cross_valid;
            end
            if (advance_result)
            begin
                result_valid_reg <= flag_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance_flag && cross_valid)
        begin
            hit_reg    <= hit_next;
            toggle_reg <= toggle_next;
        end
        if (advance_result && flag_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

/* rtl/pqt_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module pqt_checker
    import pqt_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    query_ready,
    input wire logic    result_valid,
    input wire logic    result_ready,
    input wire result_t result
);

    // A stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result word changed while stalled");

    // A point on an edge is always reported inside
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (!result.on_edge || result.inside_res))
    else $error("on_edge set without inside_res");

    // A draining output frees the whole pipeline
    assert property (@(posedge clk) disable iff (!rst_n)
        result_ready |-> query_ready)
    else $error("input stalled while output drains");

    // An empty output stage never blocks the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> query_ready)
    else $error("input stalled with empty output");

endmodule

bind point_in_quadrilateral_test pqt_checker u_pqt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .query_ready  (query_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

`default_nettype wire
